### sv/itaf_pkg.sv
// itaf_pkg: shared types and constants for the integer to ascii formatter
// no dependencies; imported by the formatter and the testbench
`default_nettype none

package itaf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PRE,
        ST_PREX,
        ST_DIGIT
    } state_t;

    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_SDEC = 2'd0;
    localparam fmt_t FMT_UDEC = 2'd1;
    localparam fmt_t FMT_HEXL = 2'd2;
    localparam fmt_t FMT_HEXU = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOWA  = 7'h61;
    localparam logic [6:0] CH_UPA   = 7'h41;
    localparam logic [6:0] CH_LOWX  = 7'h78;
    localparam logic [6:0] CH_MINUS = 7'h2d;

    localparam int HEX_MIN_DIGITS = 8;

endpackage

`default_nettype wire

### sv/int_to_ascii_formatter.sv
// int_to_ascii_formatter: binary word to ascii text, one character per request
// depends on itaf_pkg
`default_nettype none

// usage
//   slave side: s_tdata carries the word, s_tuser the format code
//   (0 signed decimal, 1 unsigned decimal, 2 hex lower, 3 hex upper)
//   master side: one request per character, most significant digit first,
//   m_tlast marks the final character of the number
// timing
//   one number at a time; s_tready is high only in the idle cycle
//   decimal: bit-serial double dabble over the VALUE_BITS bits, then leading
//   zero digits dropped one per cycle, then "-" if negative and the digits
//   hex: the word is loaded as nibbles, leading zero digits above eight are
//   dropped one per cycle, then "0x" and the digits
// reset
//   rst_n clears the state machine and counters; no request is pending
// stall
//   while m_tready is low the current character and m_tlast hold and
//   the sequencer waits
module int_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // value in the low bits, zero padded to whole bytes
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // number_format
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_char in bits 6:0, bit 7 zero
    output logic [7:0]                               m_tdata,
    // last_char
    output logic                                     m_tlast
);

    // digit capacity: enough for the decimal text and for at least eight hex digits
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int MAX_A      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int NDIG       = (MAX_A > HEX_MIN_DIGITS) ? MAX_A : HEX_MIN_DIGITS;
    localparam int DIGW       = NDIG * 4;
    localparam int CW         = $clog2(VALUE_BITS + 1);
    localparam int DW         = $clog2(NDIG + 1);

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;        // bits still to shift in
    logic [DIGW-1:0]         dig_reg, dig_next;        // digit shift register
    logic [CW-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]           dig_cnt_reg, dig_cnt_next;
    fmt_t                    fmt_reg, fmt_next;
    logic                    neg_reg, neg_next;

    logic [VALUE_BITS-1:0]   in_word;
    logic [VALUE_BITS-1:0]   in_mag;
    logic                    in_neg;
    logic                    is_hex_in;
    logic                    is_hex;
    logic [DIGW-1:0]         dig_adj;
    logic [3:0]              top_dig;
    logic [DW-1:0]           min_cnt;
    logic                    skip_more;
    logic                    out_fire;
    logic [6:0]              char_val;
    logic [6:0]              alpha_base;

    // input decode and two's complement magnitude
    assign in_word   = s_tdata[VALUE_BITS-1:0];
    assign is_hex_in = (s_tuser == FMT_HEXL) || (s_tuser == FMT_HEXU);
    assign in_neg    = (s_tuser == FMT_SDEC) && in_word[VALUE_BITS-1];
    assign in_mag    = in_neg ? (~in_word + VALUE_BITS'(1)) : in_word;

    assign is_hex    = (fmt_reg == FMT_HEXL) || (fmt_reg == FMT_HEXU);
    assign top_dig   = dig_reg[DIGW-1 -: 4];
    assign min_cnt   = is_hex ? DW'(HEX_MIN_DIGITS) : DW'(1);
    assign skip_more = (top_dig == 4'd0) && (dig_cnt_reg > min_cnt);
    assign out_fire  = m_tvalid && m_tready;

    // double dabble: add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
            begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = is_hex_in ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == CW'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!skip_more)
                begin
                    state_next = (is_hex || neg_reg) ? ST_PRE : ST_DIGIT;
                end
            end
            ST_PRE:
            begin
                if (m_tready)
                begin
                    state_next = is_hex ? ST_PREX : ST_DIGIT;
                end
            end
            ST_PREX:
            begin
                if (m_tready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (m_tready && (dig_cnt_reg == DW'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // character for the top digit
    assign alpha_base = (fmt_reg == FMT_HEXL) ? CH_LOWA : CH_UPA;
    always_comb
    begin
        if (top_dig < 4'd10)
        begin
            char_val = CH_ZERO + {3'b000, top_dig};
        end
        else
        begin
            char_val = alpha_base + {3'b000, top_dig} - 7'd10;
        end
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tdata  = 8'd0;
        m_tlast  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_PRE:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, is_hex ? CH_ZERO : CH_MINUS};
            end
            ST_PREX:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, CH_LOWX};
            end
            ST_DIGIT:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, char_val};
                m_tlast  = (dig_cnt_reg == DW'(1));
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        val_next     = val_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        fmt_next     = fmt_reg;
        neg_next     = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    fmt_next     = s_tuser;
                    neg_next     = in_neg;
                    val_next     = in_mag;
                    bit_cnt_next = CW'(VALUE_BITS);
                    dig_cnt_next = DW'(NDIG);
                    // hex digits are the nibbles themselves
                    dig_next     = is_hex_in ? DIGW'(in_mag) : '0;
                end
            end
            ST_CONV:
            begin
                dig_next     = {dig_adj[DIGW-2:0], val_reg[VALUE_BITS-1]};
                val_next     = {val_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CW'(1);
            end
            ST_SKIP:
            begin
                if (skip_more)
                begin
                    dig_next     = {dig_reg[DIGW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DW'(1);
                end
            end
            ST_DIGIT:
            begin
                if (out_fire)
                begin
                    dig_next     = {dig_reg[DIGW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DW'(1);
                end
            end
            default:
            begin
                dig_next = dig_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            fmt_reg     <= FMT_SDEC;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            fmt_reg     <= fmt_next;
            neg_reg     <= neg_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        dig_reg <= dig_next;
    end

endmodule

`default_nettype wire

### sv/itaf_checker.sv
// itaf_checker: port-level assertions for the integer to ascii formatter
// depends on int_to_ascii_formatter; bound to it at the end of this file
`default_nettype none

module itaf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // a stalled character holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled character changed");

    // never ready for a new number while characters are pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while output valid");

    // no text appears in the cycle after a new number is accepted
    a_no_early_text: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("text appeared right after request");

    // after the final character the block is idle again
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after last character");

    // characters are seven-bit ascii
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7] == 1'b0))
        else $error("character outside ascii");

endmodule

bind int_to_ascii_formatter itaf_checker u_itaf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking bench for int_to_ascii_formatter
// drives numbers in all four formats, predicts the text and checks every character
// depends on itaf_pkg and the formatter rtl
module tb_top;
    import itaf_pkg::*;

    // one expected character of the text
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // value
    logic [31:0] s_tdata = '0;
    // number_format
    logic [1:0]  s_tuser = FMT_SDEC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // out_char in bits 6:0, bit 7 zero pad
    logic [7:0]  m_tdata;
    // last_char
    logic        m_tlast;

    // characters predicted but not yet seen on the master side
    text_char_t  pending_chars[$];
    int unsigned mismatch_count = 0;
    // chance in percent that a side idles in a given cycle
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int_to_ascii_formatter #(
        .VALUE_BITS(32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ascii for one digit; letters only appear in hex
    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic [6:0] alpha);
        if (d < 4'd10)
            return CH_ZERO + 7'(d);
        return alpha + 7'(d - 4'd10);
    endfunction

    // predicts the full text of one number and queues its characters
    function automatic void format_text(input fmt_t fmt, input logic [31:0] word);
        logic [31:0] mag;
        logic [3:0]  digits[10];
        int          n;
        logic [6:0]  alpha;
        mag = word;
        n = 0;
        alpha = (fmt == FMT_HEXL) ? CH_LOWA : CH_UPA;
        if (fmt == FMT_HEXL || fmt == FMT_HEXU)
        begin
            // prefix is always lower-case, digits always zero padded to eight
            pending_chars.push_back('{CH_ZERO, 1'b0});
            pending_chars.push_back('{CH_LOWX, 1'b0});
            for (int i = HEX_MIN_DIGITS - 1; i >= 0; i--)
                pending_chars.push_back('{digit_char(mag[4*i +: 4], alpha), i == 0});
        end
        else
        begin
            // signed decimal negates, the most negative value wraps to its own magnitude
            if (fmt == FMT_SDEC && word[31])
            begin
                pending_chars.push_back('{CH_MINUS, 1'b0});
                mag = ~word + 32'd1;
            end
            do
            begin
                digits[n] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                n++;
            end while (mag != 32'd0);
            for (int i = n - 1; i >= 0; i--)
                pending_chars.push_back('{digit_char(digits[i], alpha), i == 0});
        end
    endfunction

    // receiver back-pressure, changed at the falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // character checker, sampled at the rising edge
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character request: data %h last %b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch})
                begin
                    $error("out_char: expected %h actual %h", {1'b0, want.ch}, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_char: expected %b actual %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // offers one number, holds it until accepted, then queues its predicted text
    task automatic send_number(input fmt_t fmt, input logic [31:0] word);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fmt;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        format_text(fmt, word);
    endtask

    // random word, biased toward digit-count boundaries and the sign edge
    function automatic logic [31:0] pick_word();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 20);
            1:
            begin
                // one below, at or one above a power of ten
                p = 32'd1;
                k = $urandom_range(0, 9);
                repeat (k) p = p * 32'd10;
                return p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            2: return 32'h8000_0000 + $urandom_range(0, 3) - 32'd1;
            3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            4: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // extremes of the word in every format, zero and mixed hex letters
    task automatic test_directed();
        logic [31:0] edges[5];
        edges = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        foreach (edges[i])
        begin
            send_number(FMT_SDEC, edges[i]);
            send_number(FMT_UDEC, edges[i]);
            send_number(FMT_HEXL, edges[i]);
            send_number(FMT_HEXU, edges[i]);
        end
        send_number(FMT_HEXL, 32'hABCD_EF09);
        send_number(FMT_HEXU, 32'h1234_5678);
        send_number(FMT_SDEC, 32'd1_000_000_000);
        send_number(FMT_UDEC, 32'd999_999_999);
    endtask

    // random formats and words
    task automatic test_random(input int count);
        repeat (count)
            send_number(fmt_t'($urandom_range(0, 3)), pick_word());
    endtask

    // sender holds off until the whole text of every number has come out
    task automatic test_drain_pause();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase one: sender mostly busy, receiver stalls often
        send_idle_pct = 7;
        recv_idle_pct = 54;
        test_directed();
        test_random(70);
        test_drain_pause();

        // phase two: roles swapped
        send_idle_pct = 54;
        recv_idle_pct = 7;
        test_random(70);
        test_drain_pause();

        // phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(66);

        // let the last texts drain, then a tail for stray characters
        test_drain_pause();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
